FILE: hw/rtl/shabs_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package shabs_pkg;

    // Input item: one message byte and its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } shabs_in_t;

    // Result item: one quarter of the digest
    typedef struct packed {
        logic [63:0] digest_chunk;
        logic [1:0]  chunk_index;
        logic        last_chunk;
    } shabs_out_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } shabs_state_t;

    // Source of a byte written into the block buffer
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } shabs_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       wr;
        shabs_src_t sel;
        logic       count_len;
        logic       vars_init;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold;
        logic       restart;
        logic [1:0] chunk_idx;
    } shabs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [5:0] fill;
    } shabs_stat_t;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] CHUNK_LAST = 2'd3;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/shabs_ctrl.sv
// Controller state machine: byte loading, padding, round sequencing and digest output.
module shabs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    input  logic                byte_present,
    input  logic                is_last,
    output logic                msg_stall,
    output logic                dig_valid,
    input  logic                dig_stall,
    input  shabs_pkg::shabs_stat_t stat,
    output shabs_pkg::shabs_cmd_t  cmd
);
    import shabs_pkg::*;

    shabs_state_t state_reg, state_next;
    logic         pend_last_reg, pend_last_next;
    logic         in_pad_reg, in_pad_next;
    logic         final_reg, final_next;
    logic [5:0]   round_reg, round_next;
    logic [1:0]   chunk_reg, chunk_next;
    logic         fill_at_end;

    assign fill_at_end = (stat.fill == FILL_LAST);

    // Hold state and sequencing flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pend_last_reg <= 1'b0;
            in_pad_reg    <= 1'b0;
            final_reg     <= 1'b0;
            round_reg     <= 6'd0;
            chunk_reg     <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_last_reg <= pend_last_next;
            in_pad_reg    <= in_pad_next;
            final_reg     <= final_next;
            round_reg     <= round_next;
            chunk_reg     <= chunk_next;
        end
    end

    // Decide next state and drive datapath commands
    always_comb
    begin
        state_next     = state_reg;
        pend_last_next = pend_last_reg;
        in_pad_next    = in_pad_reg;
        final_next     = final_reg;
        round_next     = round_reg;
        chunk_next     = chunk_reg;
        msg_stall      = 1'b1;
        dig_valid      = 1'b0;
        cmd            = '0;
        cmd.sel        = SRC_DATA;
        cmd.round_idx  = round_reg;
        cmd.chunk_idx  = chunk_reg;

        case (state_reg)
            ST_LOAD:
            begin
                msg_stall = 1'b0;
                if (msg_valid)
                begin
                    cmd.wr        = byte_present;
                    cmd.count_len = byte_present;
                    if (byte_present && fill_at_end)
                    begin
                        cmd.vars_init  = 1'b1;
                        round_next     = 6'd0;
                        pend_last_next = is_last;
                        state_next     = ST_ROUND;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                cmd.wr         = 1'b1;
                cmd.sel        = SRC_MARK;
                in_pad_next    = 1'b1;
                pend_last_next = 1'b0;
                if (fill_at_end)
                begin
                    cmd.vars_init = 1'b1;
                    round_next    = 6'd0;
                    state_next    = ST_ROUND;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (stat.fill == FILL_LEN)
                begin
                    state_next = ST_PADLEN;
                end
                else
                begin
                    cmd.wr  = 1'b1;
                    cmd.sel = SRC_ZERO;
                    if (fill_at_end)
                    begin
                        cmd.vars_init = 1'b1;
                        round_next    = 6'd0;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_PADLEN:
            begin
                cmd.wr  = 1'b1;
                cmd.sel = SRC_LEN;
                if (fill_at_end)
                begin
                    final_next    = 1'b1;
                    cmd.vars_init = 1'b1;
                    round_next    = 6'd0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    chunk_next = 2'd0;
                    state_next = ST_OUT;
                end
                else if (in_pad_reg)
                begin
                    state_next = ST_PADZ;
                end
                else if (pend_last_reg)
                begin
                    state_next = ST_PAD80;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                dig_valid = 1'b1;
                if (!dig_stall)
                begin
                    chunk_next = chunk_reg + 2'd1;
                    if (chunk_reg == CHUNK_LAST)
                    begin
                        cmd.restart    = 1'b1;
                        final_next     = 1'b0;
                        in_pad_next    = 1'b0;
                        pend_last_next = 1'b0;
                        state_next     = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: hw/rtl/shabs_datapath.sv
// Datapath: block buffer and schedule window, round unit, hash words and bit length.
module shabs_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  shabs_pkg::shabs_cmd_t  cmd,
    output shabs_pkg::shabs_stat_t stat,
    output shabs_pkg::shabs_out_t  dig_item
);
    import shabs_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] vars_reg [8];
    logic [31:0] vars_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [63:0] len_reg, len_next;
    logic [5:0]  fill_reg, fill_next;
    logic [7:0]  byte_val;
    logic [31:0] t1, t2, w_new;
    logic [2:0]  len_pos;

    assign len_pos = fill_reg[2:0];

    // Pick the byte to store
    always_comb
    begin
        case (cmd.sel)
            SRC_DATA: byte_val = data_byte;
            SRC_MARK: byte_val = PAD_MARK;
            SRC_ZERO: byte_val = 8'h00;
            SRC_LEN:  byte_val = len_reg[{~len_pos, 3'b000} +: 8];
            default:  byte_val = 8'h00;
        endcase
    end

    // One compression round and the next schedule word
    always_comb
    begin
        t1 = vars_reg[7] + big_sigma1(vars_reg[4])
           + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
           + round_k(cmd.round_idx) + win_reg[0];
        t2 = big_sigma0(vars_reg[0])
           + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]));
        w_new = small_sigma1(win_reg[14]) + win_reg[9]
              + small_sigma0(win_reg[1]) + win_reg[0];
    end

    // Work out next values of all storage
    always_comb
    begin
        hash_next = hash_reg;
        vars_next = vars_reg;
        win_next  = win_reg;
        len_next  = len_reg;
        fill_next = fill_reg;

        if (cmd.wr)
        begin
            win_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = byte_val;
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_len)
        begin
            len_next = len_reg + 64'd8;
        end
        if (cmd.vars_init)
        begin
            vars_next = hash_reg;
        end
        if (cmd.round_en)
        begin
            vars_next[0] = t1 + t2;
            vars_next[1] = vars_reg[0];
            vars_next[2] = vars_reg[1];
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[5] = vars_reg[4];
            vars_next[6] = vars_reg[5];
            vars_next[7] = vars_reg[6];
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_new;
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + vars_reg[i];
            end
        end
        if (cmd.restart)
        begin
            hash_next = HASH_IV;
            len_next  = 64'd0;
            fill_next = 6'd0;
        end
    end

    // Hold message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_IV;
            len_reg  <= 64'd0;
            fill_reg <= 6'd0;
        end
        else
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
            fill_reg <= fill_next;
        end
    end

    // Hold schedule window and working variables
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

    assign stat.fill = fill_reg;

    // Present the selected digest quarter
    assign dig_item.digest_chunk = {hash_reg[{cmd.chunk_idx, 1'b0}],
                                    hash_reg[{cmd.chunk_idx, 1'b1}]};
    assign dig_item.chunk_index  = cmd.chunk_idx;
    assign dig_item.last_chunk   = (cmd.chunk_idx == CHUNK_LAST);

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 byte stream hasher: top level joining controller and datapath.
//
// Usage: the msg channel carries one item per message byte (data_byte with
// byte_present set); an item with is_last set closes the message, with or
// without a byte, so an empty message is one item with only is_last set.
// The dig channel then returns the 256-bit digest as four items, chunk_index
// 0 to 3, each holding two hash words in big-endian order; last_chunk marks
// the fourth.
// Throughput: one byte a cycle while the 64-byte block fills. The item that
// completes a block holds msg_stall high while the single round unit runs
// the 64 rounds in turn and then folds the result into the hash words.
// After the last item the block writes the padding itself, up to 72 bytes
// and two compressions, before the first digest item appears. The four
// digest items follow one a cycle unless dig_stall holds them; a stalled
// item stays unchanged. No new message byte is taken until the fourth
// digest item is accepted. Reset loads the initial hash values and clears
// the byte and bit counts.
module sha256_byte_stream_hasher_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    output logic                  msg_stall,
    input  shabs_pkg::shabs_in_t  msg_item,
    output logic                  dig_valid,
    input  logic                  dig_stall,
    output shabs_pkg::shabs_out_t dig_item
);
    import shabs_pkg::*;

    shabs_cmd_t  cmd;
    shabs_stat_t stat;

    // Sequence the work
    shabs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .byte_present (msg_item.byte_present),
        .is_last      (msg_item.is_last),
        .msg_stall    (msg_stall),
        .dig_valid    (dig_valid),
        .dig_stall    (dig_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Hash the data
    shabs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg_item.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .dig_item  (dig_item)
    );

    // Never take a byte while a digest is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(dig_valid && msg_valid && !msg_stall))
    else $error("message item taken while digest pending");

    // Closing item always stops further input in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && !msg_stall && msg_item.is_last) |=> msg_stall)
    else $error("input not held after closing item");

    // Digest quarters follow in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && !dig_item.last_chunk) |=>
        (dig_valid && dig_item.chunk_index == $past(dig_item.chunk_index) + 2'd1))
    else $error("digest chunk sequence broken");

    // Digest ends after the fourth quarter
    assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && dig_item.last_chunk) |=> !dig_valid)
    else $error("digest item after last chunk");

endmodule

FILE: test/digest_checker.sv
// Checker for the SHA-256 byte stream hasher: predicts each digest and compares the chunks.
module digest_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    input  logic                  msg_stall,
    input  shabs_pkg::shabs_in_t  msg_item,
    input  logic                  dig_valid,
    input  logic                  dig_stall,
    input  shabs_pkg::shabs_out_t dig_item,
    output int                    fail_count,
    output int                    pending_chunks,
    output int                    chunks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import shabs_pkg::*;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] MARK_BYTE = 8'h80;

    // Running hash of the current message and its partly filled block
    logic [31:0] chain [8];
    logic [7:0]  msg_block [64];
    int          fill;
    logic [63:0] bit_count;

    shabs_out_t  digest_q [$];
    int          mismatches = 0;
    int          checked = 0;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // Fold the 64-byte block into the chaining words
    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] nw, t1, t2, s0, s1, w15, w2;
        int k, r;
        for (k = 0; k < 16; k++)
            w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
        for (k = 0; k < 8; k++)
            v[k] = chain[k];
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
                nw = w[r];
            else
            begin
                w15 = w[(r - 15) % 16];
                w2  = w[(r - 2) % 16];
                s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
                s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
                nw  = w[r % 16] + s0 + w[(r - 7) % 16] + s1;
                w[r % 16] = nw;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + nw;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (k = 0; k < 8; k++)
            chain[k] = chain[k] + v[k];
    endfunction

    // Pad, fold the tail, queue the four digest chunks and start afresh
    function automatic void close_message();
        shabs_out_t c;
        int i, k;
        i = fill;
        msg_block[i] = MARK_BYTE;
        i++;
        // no room left for the length: spend an extra block
        if (i > 56)
        begin
            while (i < 64)
            begin
                msg_block[i] = 8'h00;
                i++;
            end
            fold_block();
            i = 0;
        end
        while (i < 56)
        begin
            msg_block[i] = 8'h00;
            i++;
        end
        for (k = 0; k < 8; k++)
            msg_block[56 + k] = bit_count[63 - 8*k -: 8];
        fold_block();
        for (k = 0; k < 4; k++)
        begin
            c.digest_chunk = {chain[2*k], chain[2*k+1]};
            c.chunk_index  = 2'(k);
            c.last_chunk   = (k == 3);
            digest_q.insert(digest_q.size(), c);
        end
        chain     = START_HASH;
        fill      = 0;
        bit_count = '0;
    endfunction

    // Check accepted chunks, then advance the prediction on accepted items
    always @(posedge clk or negedge rst_n)
    begin
        shabs_out_t want;
        if (!rst_n)
        begin
            chain     = START_HASH;
            fill      = 0;
            bit_count = '0;
            digest_q.delete();
        end
        else
        begin
            if (dig_valid && !dig_stall)
            begin
                checked++;
                if (digest_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest_checker: unexpected chunk %h index %0d last %0b",
                                 dig_item.digest_chunk, dig_item.chunk_index,
                                 dig_item.last_chunk);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (dig_item.digest_chunk !== want.digest_chunk ||
                        dig_item.chunk_index !== want.chunk_index ||
                        dig_item.last_chunk !== want.last_chunk)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest_checker: expected %h/%0d/%0b got %h/%0d/%0b",
                                     want.digest_chunk, want.chunk_index, want.last_chunk,
                                     dig_item.digest_chunk, dig_item.chunk_index,
                                     dig_item.last_chunk);
                    end
                end
            end
            if (msg_valid && !msg_stall)
            begin
                if (msg_item.byte_present)
                begin
                    msg_block[fill] = msg_item.data_byte;
                    fill++;
                    bit_count = bit_count + 64'd8;
                    if (fill == 64)
                    begin
                        fold_block();
                        fill = 0;
                    end
                end
                if (msg_item.is_last)
                    close_message();
            end
        end
        fail_count     <= mismatches;
        pending_chunks <= digest_q.size();
        chunks_checked <= checked;
    end

endmodule

FILE: test/tb_top.sv
// Top of the SHA-256 byte stream hasher testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import shabs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 250;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       msg_valid = 1'b0;
    logic       msg_stall;
    shabs_in_t  msg_item = '0;
    logic       dig_valid;
    logic       dig_stall = 1'b0;
    shabs_out_t dig_item;

    int fail_count;
    int pending_chunks;
    int chunks_checked;

    int cycle_cnt = 0;
    int burst_left = 0;
    int items_sent = 0;
    int messages = 0;
    int msg_len = 0;
    int longest = 0;

    always #6 clk = ~clk;

    sha256_byte_stream_hasher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_item  (dig_item)
    );

    digest_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .msg_item       (msg_item),
        .dig_valid      (dig_valid),
        .dig_stall      (dig_stall),
        .dig_item       (dig_item),
        .fail_count     (fail_count),
        .pending_chunks (pending_chunks),
        .chunks_checked (chunks_checked)
    );

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Stall the digest side: random phases, each followed by a long hold-off
    initial
    begin
        int phase_len;
        int stall_pct;
        int hold;
        forever
        begin
            phase_len = $urandom_range(300, 900);
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                default: stall_pct = 60;
            endcase
            repeat (phase_len)
            begin
                @(posedge clk);
                dig_stall <= ($urandom_range(0, 99) < stall_pct);
            end
            hold = $urandom_range(200, 350);
            repeat (hold)
            begin
                @(posedge clk);
                dig_stall <= 1'b1;
            end
        end
    end

    // Offer one item in bursts with random gaps, hold it until taken
    task automatic offer(input logic [7:0] d, input logic p, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        msg_valid <= 1'b1;
        msg_item  <= shabs_in_t'{d, p, l};
        @(posedge clk);
        while (msg_stall) @(posedge clk);
        burst_left--;
        if (p || l)
            items_sent++;
        if (p)
            msg_len++;
        if (l)
        begin
            messages++;
            if (msg_len > longest)
                longest = msg_len;
            msg_len = 0;
        end
    endtask

    // Send a message of random bytes with the odd ignored item mixed in
    task automatic hash_message(input int len, input bit last_rides_byte);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer(8'($urandom_range(0, 255)), 1'b1, last_rides_byte && (i == len - 1));
        end
        if (len == 0 || !last_rides_byte)
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Hold the sender until every predicted chunk has come back
    task automatic drain();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (pending_chunks != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, with a stray byte value that must be ignored
        offer(8'hA5, 1'b0, 1'b1);
        // single zero byte carried on the closing item
        offer(8'h00, 1'b1, 1'b1);
        // single all-ones byte, closed by a separate item
        offer(8'hFF, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b1);
        // short text with an ignored item in the middle
        offer(8'h61, 1'b1, 1'b0);
        offer(8'hFF, 1'b0, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b1);
        // bytes that look like padding
        offer(8'h00, 1'b0, 1'b0);
        offer(8'h80, 1'b1, 1'b0);
        offer(8'h01, 1'b1, 1'b0);
        offer(8'h7F, 1'b1, 1'b1);
        // two empty messages back to back
        offer(8'h00, 1'b0, 1'b1);
        offer(8'hFF, 1'b0, 1'b1);
        drain();

        // tail that just fits, tail that spills into a second block, full block
        hash_message(55, 1'($urandom_range(0, 1)));
        hash_message(56, 1'($urandom_range(0, 1)));
        hash_message(64, 1'($urandom_range(0, 1)));

        // short random messages, pausing now and then for the digests
        while (items_sent < ITEM_TARGET)
        begin
            hash_message($urandom_range(0, 9), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                drain();
        end

        drain();
        repeat (260) @(posedge clk);

        $display("run summary: %0d message items in %0d messages, longest %0d bytes",
                 items_sent, messages, longest);
        $display("run summary: %0d digest chunks checked, %0d mismatches",
                 chunks_checked, fail_count);
        if (fail_count == 0 && pending_chunks == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
